// ===== rtl/core/ree_pkg.sv =====
// shared constants and types of the row edge histogram block
package ree_pkg;

  localparam int unsigned ColumnsDefault = 1024;
  localparam int unsigned PixW           = 16;
  localparam int unsigned BinW           = 11;
  localparam int unsigned CountW         = 11;
  localparam int unsigned SumW           = 20;

  localparam logic [BinW-1:0]   BinMax       = 11'd2047;
  localparam logic [CountW-1:0] CountMax     = 11'd2047;
  localparam logic [SumW-1:0]   SumMax       = 20'hFFFFF;
  localparam logic [PixW-1:0]   ThresholdRst = 16'd5;

  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StRun   = 5'b00010,
    StUpd   = 5'b00100,
    StScan  = 5'b01000,
    StDiv   = 5'b10000
  } ree_state_e;

endpackage

// ===== rtl/core/ree_if.sv =====
// stream interfaces of the row edge histogram block
interface ree_pix_if;
  import ree_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  logic            row_end;
  logic            frame_end;
  modport source (output valid, pixel, row_end, frame_end, input ready);
  modport sink   (input valid, pixel, row_end, frame_end, output ready);
endinterface

interface ree_cfg_if;
  import ree_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] threshold;
  modport source (output valid, threshold, input ready);
  modport sink   (input valid, threshold, output ready);
endinterface

interface ree_res_if #(
  parameter int unsigned PosW = $clog2(ree_pkg::ColumnsDefault) + 1
);
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] row_position;
  logic                   frame_done;
  logic signed [PosW-1:0] mode_position;
  logic signed [PosW-1:0] mean_position;
  modport source (output valid, row_position, frame_done, mode_position, mean_position,
                  input ready);
  modport sink   (input valid, row_position, frame_done, mode_position, mean_position,
                  output ready);
endinterface

// ===== rtl/core/row_edge_histogram_mode.sv =====
// top level: row edge position with per-frame histogram mode and mean
//
//  channel  dir  payload                                              transaction
//  pix_i    in   pixel, row_end, frame_end                            valid && ready
//  cfg_i    in   threshold                                            valid && ready
//  res_o    out  row_position, frame_done, mode_position, mean_position  valid && ready
//
// pixels inside a row are taken while in StRun; a row end reads its bin, then writes it back
// a frame end adds a histogram scan that clears each bin behind its read, then a divide
// of the sum by the count and a load of the result into the output register
// after reset a clearing pass runs through all Columns-1 bins of the histogram ram
// before the first pixel is taken; cfg_i is always ready
// results go through an output register; a row end waits in the write-back cycle
// while that register holds a result not yet taken
module row_edge_histogram_mode #(
  parameter int unsigned Columns = ree_pkg::ColumnsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ree_pix_if.sink   pix_i,
  ree_cfg_if.sink   cfg_i,
  ree_res_if.source res_o
);
  import ree_pkg::*;

  localparam int unsigned Bins = Columns - 1;
  localparam int unsigned AW   = $clog2(Columns);
  localparam int unsigned PosW = AW + 1;
  localparam int unsigned CW   = $clog2(Columns + 1);
  localparam logic [AW-1:0] LastBin = AW'(Bins - 1);

  ree_state_e state_q, state_d;

  logic [PixW-1:0]        thr_q;
  logic [CW-1:0]          col_q, col_d;
  logic signed [PosW-1:0] last_q, last_d;
  logic signed [PosW-1:0] pos_q, pos_d;
  logic                   frame_q, frame_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [CountW-1:0]      count_q, count_d;
  logic [AW-1:0]          cnt_q, cnt_d;
  logic                   scan_done_q, scan_done_d;
  logic                   scan_rd_q, scan_rd_d;
  logic [AW-1:0]          scan_idx_q, scan_idx_d;
  logic [BinW-1:0]        best_q, best_d;
  logic signed [PosW-1:0] mode_q, mode_d;

  logic                   out_valid_q, out_valid_d;
  logic signed [PosW-1:0] out_row_q, out_row_d;
  logic                   out_frame_q, out_frame_d;
  logic signed [PosW-1:0] out_mode_q, out_mode_d;
  logic signed [PosW-1:0] out_mean_q, out_mean_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [BinW-1:0] ram_wdata, ram_rdata;

  logic              div_start, div_busy;
  logic [SumW-1:0]   div_quo;

  logic                   in_acc, out_free, col_lt, mark, pos_ok, new_ok;
  logic signed [PosW-1:0] last_new;
  logic [SumW:0]          sum_ext;

  assign in_acc   = pix_i.valid && pix_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign col_lt   = (col_q < CW'(Columns));
  assign mark     = col_lt && (pix_i.pixel >= thr_q);
  assign last_new = mark ? PosW'(col_q) : last_q;
  // a position counts only in range 0 to Columns-2
  assign new_ok   = !last_new[PosW-1] && ({1'b0, last_new[AW-1:0]} < PosW'(Bins));
  assign pos_ok   = !pos_q[PosW-1] && ({1'b0, pos_q[AW-1:0]} < PosW'(Bins));
  assign sum_ext  = {1'b0, sum_q} + (SumW+1)'(pos_q[AW-1:0]);

  assign pix_i.ready = (state_q == StRun);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    last_d      = last_q;
    pos_d       = pos_q;
    frame_d     = frame_q;
    sum_d       = sum_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    scan_done_d = scan_done_q;
    scan_rd_d   = 1'b0;
    scan_idx_d  = scan_idx_q;
    best_d      = best_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_row_d   = out_row_q;
    out_frame_d = out_frame_q;
    out_mode_d  = out_mode_q;
    out_mean_d  = out_mean_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = '0;
    ram_raddr   = '0;
    div_start   = 1'b0;

    unique case (state_q)
      StClear: begin
        ram_we = 1'b1;
        if (cnt_q == LastBin) begin
          state_d = StRun;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      StRun: begin
        ram_raddr = new_ok ? last_new[AW-1:0] : '0;
        if (in_acc) begin
          if (pix_i.row_end || pix_i.frame_end) begin
            pos_d   = last_new;
            frame_d = pix_i.frame_end;
            col_d   = '0;
            last_d  = '1;
            state_d = StUpd;
          end else begin
            last_d = last_new;
            if (col_lt) begin
              col_d = col_q + CW'(1);
            end
          end
        end
      end
      StUpd: begin
        // hold the bin address so the read data stays put while stalled
        ram_raddr = pos_ok ? pos_q[AW-1:0] : '0;
        if (frame_q || out_free) begin
          if (pos_ok) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q[AW-1:0];
            ram_wdata = (ram_rdata < BinMax) ? ram_rdata + BinW'(1) : ram_rdata;
            sum_d     = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
            count_d   = (count_q < CountMax) ? count_q + CountW'(1) : count_q;
          end
          if (frame_q) begin
            cnt_d       = '0;
            scan_done_d = 1'b0;
            best_d      = '0;
            mode_d      = '1;
            state_d     = StScan;
          end else begin
            out_valid_d = 1'b1;
            out_row_d   = pos_q;
            out_frame_d = 1'b0;
            out_mode_d  = '0;
            out_mean_d  = '0;
            state_d     = StRun;
          end
        end
      end
      StScan: begin
        ram_raddr = cnt_q;
        if (!scan_done_q) begin
          scan_rd_d  = 1'b1;
          scan_idx_d = cnt_q;
          if (cnt_q == LastBin) begin
            scan_done_d = 1'b1;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
        if (scan_rd_q) begin
          // strict compare keeps the first of equal maxima; bin cleared behind the read
          if (ram_rdata > best_q) begin
            best_d = ram_rdata;
            mode_d = signed'({1'b0, scan_idx_q});
          end
          ram_we    = 1'b1;
          ram_waddr = scan_idx_q;
          if (scan_idx_q == LastBin) begin
            div_start = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        if (!div_busy && out_free) begin
          out_valid_d = 1'b1;
          out_row_d   = pos_q;
          out_frame_d = 1'b1;
          out_mode_d  = mode_q;
          out_mean_d  = (count_q == '0) ? '1 : signed'(div_quo[PosW-1:0]);
          sum_d       = '0;
          count_d     = '0;
          state_d     = StRun;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      thr_q       <= ThresholdRst;
      col_q       <= '0;
      last_q      <= '1;
      sum_q       <= '0;
      count_q     <= '0;
      cnt_q       <= '0;
      scan_done_q <= 1'b0;
      scan_rd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        thr_q <= cfg_i.threshold;
      end
      col_q       <= col_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      scan_done_q <= scan_done_d;
      scan_rd_q   <= scan_rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    frame_q     <= frame_d;
    scan_idx_q  <= scan_idx_d;
    best_q      <= best_d;
    mode_q      <= mode_d;
    out_row_q   <= out_row_d;
    out_frame_q <= out_frame_d;
    out_mode_q  <= out_mode_d;
    out_mean_q  <= out_mean_d;
  end

  ree_ram #(
    .Width (BinW),
    .Depth (Bins),
    .AddrW (AW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ree_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign res_o.valid         = out_valid_q;
  assign res_o.row_position  = out_row_q;
  assign res_o.frame_done    = out_frame_q;
  assign res_o.mode_position = out_mode_q;
  assign res_o.mean_position = out_mean_q;

endmodule

// ===== rtl/core/ree_ram.sv =====
// generic simple dual-port ram with registered read
module ree_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ree_div.sv =====
// restoring divider for the frame mean, one quotient bit per cycle
module ree_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ree_pkg::SumW-1:0]  dividend_i,
  input  logic [ree_pkg::CountW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [ree_pkg::SumW-1:0]  quotient_o
);
  import ree_pkg::*;

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SumW-1:0]   quo_q, quo_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic [CountW:0]   rem_sh;
  logic [CountW+1:0] diff;

  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(SumW);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
      if (!diff[CountW+1]) begin
        rem_d = diff[CountW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[CountW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule
